// File: rtl/core/lgd_pkg.sv
// Shared types, widths and constants of the lowpass gain and group delay block.
`default_nettype none

package lgd_pkg;

  // Field widths.
  localparam int unsigned FW = 25;  // frequency, Q17.8
  localparam int unsigned PW = 40;  // period and time constant, Q0.40

  // Internal datapath widths.
  localparam int unsigned XW  = 36;   // CORDIC x and y, signed Q32 with headroom
  localparam int unsigned ZW  = 34;   // CORDIC angle, signed Q30
  localparam int unsigned UVW = 34;   // 1 - cos and 1 + cos, unsigned Q32
  localparam int unsigned SQW = 80;   // 40 by 40 bit products
  localparam int unsigned DVW = 113;  // T^2 * (1 + cos)
  localparam int unsigned DGW = 116;  // 4 tau^2 (1 - cos) + T^2 (1 + cos)
  localparam int unsigned NGW = 81;   // 2 tau T
  localparam int unsigned QW  = 64;   // quotient and numerator feed width

  // Pipeline depths of the fixed parts.
  localparam int unsigned FRONT_STAGES = 6;
  localparam int unsigned PROD_STAGES  = 8;
  localparam int unsigned DIV_STEPS    = 64;
  localparam int unsigned SQRT_STEPS   = 32;

  localparam logic signed [XW-1:0] CORDIC_X0   = 36'sd2608131496;
  localparam logic signed [XW-1:0] ONE_Q32     = 36'sh1_0000_0000;
  localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;

  localparam logic [PW-1:0] SAMPLE_PERIOD_RST = 40'd10995116;
  localparam logic [FW-1:0] CHAR_FREQ_RST     = 25'd256000;

  // Configuration register indexes.
  typedef enum logic {
    REG_SAMPLE_PERIOD = 1'b0,
    REG_CHAR_FREQ     = 1'b1
  } cfg_reg_e;

  // Saturation flags that travel with an item.
  typedef struct packed {
    logic gsat;
    logic dsat;
  } sat_t;

  // Arctangent of 2^-i in Q30 for the first ten rotations.
  localparam logic [31:0] ATAN_Q30 [10] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD
  };

  // Rotation angle of one CORDIC stage; a power of two past the table, zero past 30.
  function automatic logic [ZW-1:0] stage_atan(input int unsigned i);
    logic [ZW-1:0] a;
    if (i < 10) begin
      a = ZW'(ATAN_Q30[4'(i)]);
    end else if (i <= 30) begin
      a = ZW'(1) << (30 - i);
    end else begin
      a = '0;
    end
    return a;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lgd_front.sv
// Phase front end: frequency offset, phase in turns, quadrant fold and angle in radians.
`default_nettype none

module lgd_front import lgd_pkg::*; (
  input  wire                     clk_i,
  input  wire                     en_i,
  input  wire  [FW-1:0]           center_freq_i,
  input  wire  [PW-1:0]           time_constant_i,
  input  wire  [PW-1:0]           period_i,
  input  wire  [FW-1:0]           char_freq_i,
  output logic signed [ZW-1:0]    z_o,
  output logic                    flip_o,
  output logic [PW-1:0]           tau_o
);

  logic [FW-1:0] diff_q, diff_d;
  logic [PW-1:0] tau1_q, tau2_q, tau3_q, tau4_q, tau5_q, tau6_q;
  logic [48:0]   m1_q, m1_d;
  logic [40:0]   m2_q, m2_d;
  logic [47:0]   sum48;
  logic [31:0]   p_q, p_d;
  logic [31:0]   s_turn, rr;
  logic [31:0]   m_q, m_d;
  logic          flip4_q, flip5_q, flip6_q, flip_d;
  logic [62:0]   zp_q, zp_d, zr;
  logic [ZW-1:0] z_q, z_d;

  // Absolute frequency offset.
  assign diff_d = (center_freq_i >= char_freq_i) ? (center_freq_i - char_freq_i)
                                                 : (char_freq_i - center_freq_i);

  // Offset times period, split on the period so each product stays narrow.
  assign m1_d = {24'b0, diff_q} * {25'b0, period_i[23:0]};
  assign m2_d = {16'b0, diff_q} * {25'b0, period_i[39:24]};

  // Phase modulo one turn, cut to Q0.32 turns.
  assign sum48 = m1_q[47:0] + {m2_q[23:0], 24'b0};
  assign p_d   = sum48[47:16];

  // Fold turns in [1/4, 3/4) by a half turn, then take the magnitude.
  assign s_turn = p_q + 32'h4000_0000;
  assign flip_d = s_turn[31];
  assign rr     = p_q - (flip_d ? 32'h8000_0000 : 32'h0);
  assign m_d    = rr[31] ? (32'h0 - rr) : rr;

  // Turns to radians in Q30, rounded to nearest.
  assign zp_d = {31'b0, m_q} * {32'b0, HALF_PI_Q30};
  assign zr   = zp_q + 63'h2000_0000;
  assign z_d  = {1'b0, zr[62:30]};

  // Stage registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      diff_q  <= diff_d;
      tau1_q  <= time_constant_i;
      m1_q    <= m1_d;
      m2_q    <= m2_d;
      tau2_q  <= tau1_q;
      p_q     <= p_d;
      tau3_q  <= tau2_q;
      m_q     <= m_d;
      flip4_q <= flip_d;
      tau4_q  <= tau3_q;
      zp_q    <= zp_d;
      flip5_q <= flip4_q;
      tau5_q  <= tau4_q;
      z_q     <= z_d;
      flip6_q <= flip5_q;
      tau6_q  <= tau5_q;
    end
  end

  assign z_o    = z_q;
  assign flip_o = flip6_q;
  assign tau_o  = tau6_q;

endmodule

`default_nettype wire

// File: rtl/core/lgd_cordic_cell.sv
// One CORDIC rotation cell with a registered output and a side channel.
`default_nettype none

module lgd_cordic_cell import lgd_pkg::*; #(
  parameter int unsigned STAGE = 0,
  parameter int unsigned SW    = 1
) (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire  signed [XW-1:0]  x_i,
  input  wire  signed [XW-1:0]  y_i,
  input  wire  signed [ZW-1:0]  z_i,
  input  wire  [SW-1:0]         sb_i,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic signed [ZW-1:0]  z_o,
  output logic [SW-1:0]         sb_o
);

  localparam logic signed [ZW-1:0] ATAN = stage_atan(STAGE);

  logic signed [XW-1:0] sx, sy, x_d, y_d, x_q, y_q;
  logic signed [ZW-1:0] z_d, z_q;
  logic [SW-1:0]        sb_q;

  // Rotate toward zero residual angle; arithmetic shifts round down.
  always_comb begin
    sx = x_i >>> STAGE;
    sy = y_i >>> STAGE;
    if (!z_i[ZW-1]) begin
      x_d = x_i - sy;
      y_d = y_i + sx;
      z_d = z_i - ATAN;
    end else begin
      x_d = x_i + sy;
      y_d = y_i - sx;
      z_d = z_i + ATAN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      sb_q <= sb_i;
    end
  end

  assign x_o  = x_q;
  assign y_o  = y_q;
  assign z_o  = z_q;
  assign sb_o = sb_q;

endmodule

`default_nettype wire

// File: rtl/core/lgd_prod.sv
// Cosine clamp, squared terms and the gain and delay denominators with saturation checks.
`default_nettype none

module lgd_prod import lgd_pkg::*; (
  input  wire                   clk_i,
  input  wire                   en_i,
  input  wire  signed [XW-1:0]  x_i,
  input  wire                   flip_i,
  input  wire  [PW-1:0]         tau_i,
  input  wire  [PW-1:0]         period_i,
  output logic [DVW-1:0]        dv_o,
  output logic [DGW-1:0]        dg_o,
  output logic [NGW-1:0]        ng_o,
  output sat_t                  sat_o
);

  logic signed [XW-1:0] xc, cs, u_full, v_full;
  logic [UVW-1:0] u_q, v_q, u1_q, v1_q, u2_q, v2_q;
  logic [PW-1:0]  tau_q;
  logic [19:0]    tl, th, pl, ph;
  logic [39:0]    aa_ll_q, aa_lh_q, aa_hh_q, bb_ll_q, bb_lh_q, bb_hh_q;
  logic [39:0]    gg_ll_q, gg_lh_q, gg_hl_q, gg_hh_q;
  logic [SQW-1:0] tau2_q, tt_q, tg;
  logic [NGW-1:0] ng2_q, ng3_q, ng4_q, ng5_q, ng6_q, ng7_q;
  logic [53:0]    pa_d [4];
  logic [53:0]    pb_d [4];
  logic [53:0]    pa_q [4];
  logic [53:0]    pb_q [4];
  logic [73:0]    sa01_q, sa23_q, sb01_q, sb23_q;
  logic [DVW-1:0] a_q, dv5_q, dv6_q, dv7_q;
  logic [DGW-1:0] dg6_q, dg7_q;
  sat_t           sat_d, sat_q;

  // Clamp the cosine to [-1, 1], undo the fold, form 1 - cos and 1 + cos.
  always_comb begin
    if (x_i > ONE_Q32) begin
      xc = ONE_Q32;
    end else if (x_i < -ONE_Q32) begin
      xc = -ONE_Q32;
    end else begin
      xc = x_i;
    end
    cs     = flip_i ? -xc : xc;
    u_full = ONE_Q32 - cs;
    v_full = ONE_Q32 + cs;
  end

  assign tl = tau_q[19:0];
  assign th = tau_q[39:20];
  assign pl = period_i[19:0];
  assign ph = period_i[39:20];

  // Wide products against 1 - cos and 1 + cos, in 20 bit slices.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      pa_d[k] = 54'(tau2_q[20*k +: 20]) * 54'(u2_q);
      pb_d[k] = 54'(tt_q[20*k +: 20]) * 54'(v2_q);
    end
  end

  assign tg = {gg_hh_q, 40'b0} + SQW'({gg_lh_q, 20'b0}) + SQW'({gg_hl_q, 20'b0})
            + SQW'(gg_ll_q);

  // Saturation checks on the finished denominators.
  always_comb begin
    sat_d.gsat = (dv6_q == '0) || (DVW'(dg6_q[DGW-1:32]) >= dv6_q);
    sat_d.dsat = (dg6_q == '0) || (DGW'({ng6_q, 17'b0}) >= dg6_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // Cosine terms.
      u_q   <= UVW'(u_full);
      v_q   <= UVW'(v_full);
      tau_q <= tau_i;
      // Slice products of tau^2, T^2 and tau T.
      aa_ll_q <= 40'(tl) * 40'(tl);
      aa_lh_q <= 40'(tl) * 40'(th);
      aa_hh_q <= 40'(th) * 40'(th);
      bb_ll_q <= 40'(pl) * 40'(pl);
      bb_lh_q <= 40'(pl) * 40'(ph);
      bb_hh_q <= 40'(ph) * 40'(ph);
      gg_ll_q <= 40'(tl) * 40'(pl);
      gg_lh_q <= 40'(tl) * 40'(ph);
      gg_hl_q <= 40'(th) * 40'(pl);
      gg_hh_q <= 40'(th) * 40'(ph);
      u1_q    <= u_q;
      v1_q    <= v_q;
      // Squares and the delay numerator.
      tau2_q <= {aa_hh_q, 40'b0} + SQW'({aa_lh_q, 21'b0}) + SQW'(aa_ll_q);
      tt_q   <= {bb_hh_q, 40'b0} + SQW'({bb_lh_q, 21'b0}) + SQW'(bb_ll_q);
      ng2_q  <= {tg, 1'b0};
      u2_q   <= u1_q;
      v2_q   <= v1_q;
      // Partial products and their sums.
      for (int k = 0; k < 4; k++) begin
        pa_q[k] <= pa_d[k];
        pb_q[k] <= pb_d[k];
      end
      ng3_q  <= ng2_q;
      sa01_q <= 74'(pa_q[0]) + {pa_q[1], 20'b0};
      sa23_q <= 74'(pa_q[2]) + {pa_q[3], 20'b0};
      sb01_q <= 74'(pb_q[0]) + {pb_q[1], 20'b0};
      sb23_q <= 74'(pb_q[2]) + {pb_q[3], 20'b0};
      ng4_q  <= ng3_q;
      a_q    <= DVW'(sa01_q) + DVW'({sa23_q, 40'b0});
      dv5_q  <= DVW'(sb01_q) + DVW'({sb23_q, 40'b0});
      ng5_q  <= ng4_q;
      // Gain denominator.
      dg6_q <= (DGW'(a_q) << 2) + DGW'(dv5_q);
      dv6_q <= dv5_q;
      ng6_q <= ng5_q;
      // Flags.
      dg7_q <= dg6_q;
      dv7_q <= dv6_q;
      ng7_q <= ng6_q;
      sat_q <= sat_d;
    end
  end

  assign dv_o  = dv7_q;
  assign dg_o  = dg7_q;
  assign ng_o  = ng7_q;
  assign sat_o = sat_q;

endmodule

`default_nettype wire

// File: rtl/core/lgd_div_cell.sv
// One restoring division step: shifts in a numerator bit and develops one quotient bit.
`default_nettype none

module lgd_div_cell import lgd_pkg::*; #(
  parameter int unsigned DW = 113,
  parameter int unsigned SW = 1
) (
  input  wire           clk_i,
  input  wire           en_i,
  input  wire  [DW-1:0] r_i,
  input  wire  [DW-1:0] d_i,
  input  wire  [QW-1:0] n_i,
  input  wire  [QW-1:0] q_i,
  input  wire  [SW-1:0] sb_i,
  output logic [DW-1:0] r_o,
  output logic [DW-1:0] d_o,
  output logic [QW-1:0] n_o,
  output logic [QW-1:0] q_o,
  output logic [SW-1:0] sb_o
);

  logic [DW:0]   trial, diff;
  logic          ge;
  logic [DW-1:0] r_d, r_q, d_q;
  logic [QW-1:0] n_q, q_q;
  logic [SW-1:0] sb_q;

  // Compare the shifted remainder against the divisor.
  assign trial = {r_i, n_i[QW-1]};
  assign ge    = trial >= {1'b0, d_i};
  assign diff  = trial - {1'b0, d_i};
  assign r_d   = ge ? diff[DW-1:0] : trial[DW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q  <= r_d;
      d_q  <= d_i;
      n_q  <= {n_i[QW-2:0], 1'b0};
      q_q  <= {q_i[QW-2:0], ge};
      sb_q <= sb_i;
    end
  end

  assign r_o  = r_q;
  assign d_o  = d_q;
  assign n_o  = n_q;
  assign q_o  = q_q;
  assign sb_o = sb_q;

endmodule

`default_nettype wire

// File: rtl/core/lgd_sqrt_cell.sv
// One digit step of the integer square root.
`default_nettype none

module lgd_sqrt_cell import lgd_pkg::*; #(
  parameter int unsigned STEP = 0,
  parameter int unsigned SW   = 1
) (
  input  wire           clk_i,
  input  wire           en_i,
  input  wire  [QW-1:0] v_i,
  input  wire  [QW-1:0] res_i,
  input  wire  [SW-1:0] sb_i,
  output logic [QW-1:0] v_o,
  output logic [QW-1:0] res_o,
  output logic [SW-1:0] sb_o
);

  localparam logic [QW-1:0] BIT = QW'(1) << (QW - 2 - 2 * STEP);

  logic [QW-1:0] trial, v_d, res_d, v_q, res_q;
  logic [SW-1:0] sb_q;
  logic          ge;

  // Take the digit if the remainder allows it.
  assign trial = res_i + BIT;
  assign ge    = v_i >= trial;
  assign v_d   = ge ? (v_i - trial) : v_i;
  assign res_d = ge ? ((res_i >> 1) + BIT) : (res_i >> 1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q   <= v_d;
      res_q <= res_d;
      sb_q  <= sb_i;
    end
  end

  assign v_o   = v_q;
  assign res_o = res_q;
  assign sb_o  = sb_q;

endmodule

`default_nettype wire

// File: rtl/core/lowpass_gain_group_delay.sv
// Top level of the lowpass gain and group delay pipeline.
// The block accepts one transaction per clock and returns one result per transaction,
// in order, through 6 phase stages, one cell per CORDIC rotation, 8 product stages,
// 64 division cells (gain and delay side by side), 32 square root cells and the output
// register. The whole pipeline holds while a result waits at the output, so in_ready_o
// follows out_ready_i whenever a result is pending. Configuration writes take effect at once
// and are to be made by the user while the pipeline is empty; the block does not enforce it.
`default_nettype none

module lowpass_gain_group_delay import lgd_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  // Configuration write port.
  input  wire                cfg_we_i,
  input  wire  [0:0]         cfg_index_i,
  input  wire  [PW-1:0]      cfg_data_i,
  // Input channel.
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [FW-1:0]      center_freq_i,
  input  wire  [PW-1:0]      time_constant_i,
  // Output channel.
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [31:0]        wideband_gain_o,
  output logic               gain_saturated_o,
  output logic signed [31:0] group_delay_o
);

  localparam int unsigned LAT = FRONT_STAGES + CORDIC_STAGES + PROD_STAGES + DIV_STEPS
                              + SQRT_STEPS + 1;
  localparam int unsigned CSW  = PW + 1;
  localparam int unsigned SQSW = 33;

  logic [PW-1:0] period_q;
  logic [FW-1:0] char_freq_q;
  logic          pipe_en;
  logic [LAT-1:0] vld_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q    <= SAMPLE_PERIOD_RST;
      char_freq_q <= CHAR_FREQ_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_SAMPLE_PERIOD: period_q    <= cfg_data_i;
        REG_CHAR_FREQ:     char_freq_q <= cfg_data_i[FW-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves unless a finished result is waiting.
  assign pipe_en    = !out_valid_o || out_ready_i;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[LAT-1];

  // Phase front end.
  logic signed [ZW-1:0] fz;
  logic                 fflip;
  logic [PW-1:0]        ftau;

  lgd_front u_front (
    .clk_i           (clk_i),
    .en_i            (pipe_en),
    .center_freq_i   (center_freq_i),
    .time_constant_i (time_constant_i),
    .period_i        (period_q),
    .char_freq_i     (char_freq_q),
    .z_o             (fz),
    .flip_o          (fflip),
    .tau_o           (ftau)
  );

  // CORDIC row.
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cz [CORDIC_STAGES+1];
  logic [CSW-1:0]       csb [CORDIC_STAGES+1];

  assign cx[0]  = CORDIC_X0;
  assign cy[0]  = '0;
  assign cz[0]  = fz;
  assign csb[0] = {fflip, ftau};

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    lgd_cordic_cell #(.STAGE(i), .SW(CSW)) u_cell (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .sb_i  (csb[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1]),
      .sb_o  (csb[i+1])
    );
  end

  // Products and denominators.
  logic [DVW-1:0] pdv;
  logic [DGW-1:0] pdg;
  logic [NGW-1:0] png;
  sat_t           psat;

  lgd_prod u_prod (
    .clk_i    (clk_i),
    .en_i     (pipe_en),
    .x_i      (cx[CORDIC_STAGES]),
    .flip_i   (csb[CORDIC_STAGES][PW]),
    .tau_i    (csb[CORDIC_STAGES][PW-1:0]),
    .period_i (period_q),
    .dv_o     (pdv),
    .dg_o     (pdg),
    .ng_o     (png),
    .sat_o    (psat)
  );

  // Division rows: gain^2 in Q32 and the delay in Q16.16, side by side.
  logic [DVW-1:0] gr [DIV_STEPS+1];
  logic [DVW-1:0] gdv [DIV_STEPS+1];
  logic [QW-1:0]  gn [DIV_STEPS+1];
  logic [QW-1:0]  gq [DIV_STEPS+1];
  logic [0:0]     gsb [DIV_STEPS+1];
  logic [DGW-1:0] dr [DIV_STEPS+1];
  logic [DGW-1:0] ddv [DIV_STEPS+1];
  logic [QW-1:0]  dn [DIV_STEPS+1];
  logic [QW-1:0]  dq [DIV_STEPS+1];
  logic [0:0]     dsb [DIV_STEPS+1];

  assign gr[0]  = DVW'(pdg[DGW-1:32]);
  assign gdv[0] = pdv;
  assign gn[0]  = {pdg[31:0], 32'b0};
  assign gq[0]  = '0;
  assign gsb[0] = psat.gsat;
  assign dr[0]  = DGW'(png[NGW-1:16]);
  assign ddv[0] = pdg;
  assign dn[0]  = {png[15:0], 48'b0};
  assign dq[0]  = '0;
  assign dsb[0] = psat.dsat;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    lgd_div_cell #(.DW(DVW), .SW(1)) u_gain (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .r_i   (gr[k]),
      .d_i   (gdv[k]),
      .n_i   (gn[k]),
      .q_i   (gq[k]),
      .sb_i  (gsb[k]),
      .r_o   (gr[k+1]),
      .d_o   (gdv[k+1]),
      .n_o   (gn[k+1]),
      .q_o   (gq[k+1]),
      .sb_o  (gsb[k+1])
    );
    lgd_div_cell #(.DW(DGW), .SW(1)) u_delay (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .r_i   (dr[k]),
      .d_i   (ddv[k]),
      .n_i   (dn[k]),
      .q_i   (dq[k]),
      .sb_i  (dsb[k]),
      .r_o   (dr[k+1]),
      .d_o   (ddv[k+1]),
      .n_o   (dn[k+1]),
      .q_o   (dq[k+1]),
      .sb_o  (dsb[k+1])
    );
  end

  // Square root row; flags and delay quotient ride along.
  logic [QW-1:0]   sv [SQRT_STEPS+1];
  logic [QW-1:0]   sres [SQRT_STEPS+1];
  logic [SQSW-1:0] ssb [SQRT_STEPS+1];

  assign sv[0]   = gq[DIV_STEPS];
  assign sres[0] = '0;
  assign ssb[0]  = {gsb[DIV_STEPS], dsb[DIV_STEPS], dq[DIV_STEPS][30:0]};

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    lgd_sqrt_cell #(.STEP(s), .SW(SQSW)) u_cell (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .v_i   (sv[s]),
      .res_i (sres[s]),
      .sb_i  (ssb[s]),
      .v_o   (sv[s+1]),
      .res_o (sres[s+1]),
      .sb_o  (ssb[s+1])
    );
  end

  // Output register with saturation applied.
  logic [31:0] gain_q, delay_q;
  logic        gflag_q;
  logic [SQSW-1:0] last_sb;

  assign last_sb = ssb[SQRT_STEPS];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      gain_q  <= last_sb[32] ? 32'hFFFF_FFFF : sres[SQRT_STEPS][31:0];
      gflag_q <= last_sb[32];
      delay_q <= last_sb[31] ? 32'h7FFF_FFFF : {1'b0, last_sb[30:0]};
    end
  end

  assign wideband_gain_o  = gain_q;
  assign gain_saturated_o = gflag_q;
  assign group_delay_o    = $signed(delay_q);

`ifndef ASSERT_OFF
  a_sat_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && gain_saturated_o |-> wideband_gain_o == 32'hFFFF_FFFF)
    else $error("saturated gain is not full scale");
  a_delay_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !group_delay_o[31])
    else $error("group delay is negative");
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> vld_q[0])
    else $error("accepted transaction did not enter the pipeline");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(vld_q))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

// File: sim/lowpass_gain_group_delay_test.sv
// Self-checking testbench of the lowpass gain and group delay block.
`timescale 1ns / 1ps

module lowpass_gain_group_delay_test;
  import lgd_pkg::*;

  localparam int unsigned STAGES  = 24;
  localparam int unsigned LATENCY = STAGES + 111;

  typedef struct {
    logic [FW-1:0] fc;
    logic [PW-1:0] tau;
  } filter_item_t;

  typedef struct {
    logic [31:0] gain;
    logic        sat;
    logic [31:0] delay;
  } response_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [0:0]        cfg_index_i = '0;
  logic [PW-1:0]     cfg_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [FW-1:0]     center_freq_i = '0;
  logic [PW-1:0]     time_constant_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [31:0]       wideband_gain_o;
  logic              gain_saturated_o;
  logic signed [31:0] group_delay_o;

  filter_item_t pending_items[$];
  response_t    expected_responses[$];
  logic [PW-1:0] period_reg = SAMPLE_PERIOD_RST;
  logic [FW-1:0] char_freq_reg = CHAR_FREQ_RST;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  int unsigned n_checked = 0;
  int unsigned n_settings = 0;
  int unsigned n_saturated = 0;
  int unsigned n_errors = 0;

  lowpass_gain_group_delay #(.CORDIC_STAGES(STAGES)) u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .center_freq_i, .time_constant_i,
    .out_valid_o, .out_ready_i, .wideband_gain_o, .gain_saturated_o, .group_delay_o
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Angle of one rotation in Q30.
  function automatic logic signed [63:0] rotation_angle(input int unsigned i);
    if (i < 10) return 64'(ATAN_Q30[i]);
    if (i <= 30) return 64'sd1 <<< (30 - i);
    return 64'sd0;
  endfunction

  // Cosine of a Q0.32 phase in turns, as Q32 clamped to [-1, 1].
  function automatic logic signed [63:0] cosine_q32(input logic [31:0] p);
    logic [31:0] s, rr;
    logic flip;
    logic [63:0] m, zp;
    logic signed [63:0] x, y, z, nx;
    s = p + 32'h4000_0000;
    flip = s[31];
    rr = p - (flip ? 32'h8000_0000 : 32'h0);
    m = rr[31] ? 64'h1_0000_0000 - 64'(rr) : 64'(rr);
    zp = (m * 64'(HALF_PI_Q30) + 64'h2000_0000) >> 30;
    z = $signed(zp);
    x = 64'sd2608131496;
    y = 64'sd0;
    for (int unsigned i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - rotation_angle(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + rotation_angle(i);
      end
      x = nx;
    end
    if (x > 64'sh1_0000_0000) x = 64'sh1_0000_0000;
    if (x < -64'sh1_0000_0000) x = -64'sh1_0000_0000;
    return flip ? -x : x;
  endfunction

  // Integer square root, rounded down.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = '0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Gain and group delay of the lowpass for one transaction.
  function automatic response_t lowpass_response(input filter_item_t it);
    response_t r;
    logic [FW-1:0] diff;
    logic [63:0] phase, u, v, q;
    logic signed [63:0] c;
    logic [255:0] dv, dg, ng, qd;
    diff = (it.fc >= char_freq_reg) ? it.fc - char_freq_reg : char_freq_reg - it.fc;
    phase = 64'(diff) * 64'(period_reg);
    c = cosine_q32(phase[47:16]);
    u = 64'sh1_0000_0000 - c;
    v = 64'sh1_0000_0000 + c;
    dv = 256'(period_reg) * 256'(period_reg) * 256'(v);
    dg = ((256'(it.tau) * 256'(it.tau) * 256'(u)) << 2) + dv;
    ng = (256'(it.tau) * 256'(period_reg)) << 1;
    if (dv == 0 || (dg >> 32) >= dv) begin
      r.gain = 32'hFFFF_FFFF;
      r.sat = 1'b1;
    end else begin
      qd = (dg << 32) / dv;
      q = qd[63:0];
      r.gain = floor_sqrt(q) & 64'hFFFF_FFFF;
      r.sat = 1'b0;
    end
    if (dg == 0 || (ng << 17) >= dg) begin
      r.delay = 32'h7FFF_FFFF;
    end else begin
      qd = (ng << 48) / dg;
      r.delay = qd[31:0];
    end
    return r;
  endfunction

  // Driver: presents queued transactions, idling at the configured rate.
  always @(posedge clk_i or negedge rst_ni) begin
    filter_item_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_responses.push_back(lowpass_response('{center_freq_i, time_constant_i}));
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_items.pop_front();
          center_freq_i <= nxt.fc;
          time_constant_i <= nxt.tau;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the output at random and checks each result in order.
  always @(posedge clk_i or negedge rst_ni) begin
    response_t e;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_idle_pct);
      if (out_valid_o && out_ready_i) begin
        if (expected_responses.size() == 0) begin
          $error("unexpected result: gain %h delay %h", wideband_gain_o, group_delay_o);
          n_errors++;
        end else begin
          e = expected_responses.pop_front();
          n_checked++;
          if (e.sat) n_saturated++;
          if (wideband_gain_o !== e.gain) begin
            $error("wideband_gain: expected %h, got %h", e.gain, wideband_gain_o);
            n_errors++;
          end
          if (gain_saturated_o !== e.sat) begin
            $error("gain_saturated: expected %b, got %b", e.sat, gain_saturated_o);
            n_errors++;
          end
          if (group_delay_o !== e.delay) begin
            $error("group_delay: expected %h, got %h", e.delay, group_delay_o);
            n_errors++;
          end
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_responses.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [PW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SAMPLE_PERIOD) period_reg = data;
    else char_freq_reg = data[FW-1:0];
  endtask

  task automatic set_filter(input logic [PW-1:0] t, input logic [FW-1:0] cf);
    write_reg(REG_SAMPLE_PERIOD, t);
    write_reg(REG_CHAR_FREQ, cf);
    n_settings++;
  endtask

  task automatic add(input logic [FW-1:0] fc, input logic [PW-1:0] tau);
    pending_items.push_back('{fc, tau});
  endtask

  // Random time constants: full range, small, and exact multiples of the period.
  function automatic logic [PW-1:0] random_tau();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(2))
      0: return r[PW-1:0];
      1: return r[PW-1:0] >> $urandom_range(39);
      default: return PW'(64'(period_reg) * $urandom_range(4000));
    endcase
  endfunction

  task automatic add_random(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(3) == 0) add(char_freq_reg + FW'($urandom_range(4096)), random_tau());
      else add(FW'($urandom), random_tau());
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: field extremes, zero offset, pause until drained mid-phase.
    sender_idle_pct = 26;
    receiver_idle_pct = 75;
    set_filter(SAMPLE_PERIOD_RST, CHAR_FREQ_RST);
    add('0, '0);
    add('1, '0);
    add('0, '1);
    add('1, '1);
    add(CHAR_FREQ_RST, 40'd1);
    add(CHAR_FREQ_RST, '1);
    add(CHAR_FREQ_RST, SAMPLE_PERIOD_RST);
    add(CHAR_FREQ_RST + 25'd256, SAMPLE_PERIOD_RST);
    add(25'h155_5555, 40'hAA_AAAA_AAAA);
    add(25'h0AA_AAAA, 40'h55_5555_5555);
    add_random(150);
    wait_drained();
    add_random(150);
    wait_drained();

    // Half-turn phase: cosine of minus one zeroes the gain denominator.
    sender_idle_pct = 75;
    receiver_idle_pct = 26;
    set_filter(40'h80_0000_0000, 25'd25600);
    add(25'd25856, 40'd1000);
    add(25'd25344, '1);
    add(25'd25856, '0);
    add(25'd25600, 40'd12345);
    add_random(300);
    wait_drained();

    // Shortest period, zero frequency: delay and gain overflow.
    set_filter(40'd1, '0);
    add('0, '1);
    add('0, 40'd32768);
    add('0, 40'd32767);
    add('1, '1);
    add_random(300);
    wait_drained();

    // Longest period, highest frequency.
    sender_idle_pct = 0;
    receiver_idle_pct = 0;
    set_filter('1, '1);
    add('1, '1);
    add('0, '1);
    add_random(300);
    wait_drained();

    // Random settings around the nominal period.
    repeat (4) begin
      set_filter(PW'($urandom_range(1, 40000000)), FW'($urandom));
      add_random(170);
      wait_drained();
    end

    $display("summary: %0d results checked (%0d gain saturated) over %0d filter settings",
             n_checked, n_saturated, n_settings);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/lgd_pkg.sv
rtl/core/lgd_front.sv
rtl/core/lgd_cordic_cell.sv
rtl/core/lgd_prod.sv
rtl/core/lgd_div_cell.sv
rtl/core/lgd_sqrt_cell.sv
rtl/core/lowpass_gain_group_delay.sv
sim/lowpass_gain_group_delay_test.sv
